/* design/tori_pkg.sv */
// ---------------------------------------------------------------------------
// tori_pkg
// Shared types, widths and codes for the triangle orientation ray parity block.
// ---------------------------------------------------------------------------
`default_nettype none

package tori_pkg;

  localparam int COORD_BITS       = 32;
  localparam int MAX_TRIANGLES_DEF = 1024;
  localparam int IDX_W            = 10;
  localparam int FLIP_W           = 11;
  localparam int FLIP_TOTAL_MAX   = 1024;
  localparam int CFG_W            = 32;
  localparam int CFG_IDX_W        = 3;
  localparam int MARGIN_W         = 16;
  localparam int ROW_WORDS        = 9;

  localparam int EDGE_W  = COORD_BITS + 1;
  localparam int NPROD_W = 2 * EDGE_W;
  localparam int N_W     = NPROD_W + 1;
  localparam int SUM_W   = COORD_BITS + 2;
  localparam int P3_W    = COORD_BITS + 3;
  localparam int PROD_W  = 2 * P3_W;
  localparam int UVW_W   = PROD_W + 1;
  localparam int D_W     = UVW_W + 2;
  localparam int SPLIT   = P3_W;
  localparam int HI_W    = UVW_W - SPLIT;
  localparam int E_W     = UVW_W + P3_W + 2;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_TEST   = 2'd2;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_X_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Z_LOW   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Z_HIGH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_THREE_D = 3'd7;

  typedef struct packed {
    logic [1:0]                   mode;
    logic [IDX_W-1:0]             tri_index;
    logic signed [COORD_BITS-1:0] v0_x;
    logic signed [COORD_BITS-1:0] v0_y;
    logic signed [COORD_BITS-1:0] v0_z;
    logic signed [COORD_BITS-1:0] v1_x;
    logic signed [COORD_BITS-1:0] v1_y;
    logic signed [COORD_BITS-1:0] v1_z;
    logic signed [COORD_BITS-1:0] v2_x;
    logic signed [COORD_BITS-1:0] v2_y;
    logic signed [COORD_BITS-1:0] v2_z;
  } tori_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  tested_index;
    logic              flip;
    logic              bad_index;
    logic [FLIP_W-1:0] flip_total;
  } tori_out_t;

  typedef struct packed {
    logic signed [CFG_W-1:0] x_low;
    logic signed [CFG_W-1:0] x_high;
    logic signed [CFG_W-1:0] y_low;
    logic signed [CFG_W-1:0] y_high;
    logic signed [CFG_W-1:0] z_low;
    logic signed [CFG_W-1:0] z_high;
    logic [MARGIN_W-1:0]     margin;
    logic                    three_d;
  } tori_cfg_t;

  typedef struct packed {
    logic                    skip;
    logic [1:0]              k;
    logic                    ls_neg;
    logic signed [SUM_W-1:0] lo3;
    logic signed [SUM_W-1:0] hi3;
    logic signed [SUM_W-1:0] sum0;
    logic signed [SUM_W-1:0] sum1;
    logic signed [SUM_W-1:0] sum2;
    logic [MARGIN_W-1:0]     margin;
  } tori_ctx_t;

  typedef logic [ROW_WORDS-1:0][COORD_BITS-1:0] tori_row_t;

endpackage

`default_nettype wire

/* design/triangle_orientation_ray_parity.sv */
// A bad index result appears the cycle after the beat.
// A full test reads all N stored triangles: the store's single read port
// feeds one triangle per cycle into a seven-stage pipeline.
// A triangle skipped at setup reports without a scan; no overlap of tests.
// Reset clears counts and control, zeroes the bounds, sets margin and three_d
// to one; store contents are undefined.
// ---------------------------------------------------------------------------
// triangle_orientation_ray_parity
// Triangle store with ray parity orientation test and running flip total.
// ---------------------------------------------------------------------------
`default_nettype none

module triangle_orientation_ray_parity import tori_pkg::*; #(
  parameter int MAX_TRIANGLES = MAX_TRIANGLES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  tori_in_t             in_data,
  output logic                 out_valid,
  output tori_out_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int AW    = $clog2(MAX_TRIANGLES);
  localparam int CNT_W = $clog2(MAX_TRIANGLES + 1);
  localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  typedef enum logic [1:0] {ST_IDLE, ST_SETUP, ST_SCAN, ST_DRAIN} state_t;

  state_t           state_r;
  tori_cfg_t        cfg_r;
  logic [CNT_W-1:0] count_r;
  logic [FLIP_W-1:0] flips_r, flips_nxt;
  logic [AW-1:0]    q_r, t_r;
  logic [IDX_W-1:0] idx_r;
  logic             load_r, rd_pend_r, self_r, parity_r;
  logic             out_valid_r;
  tori_out_t        out_r;

  logic             accept, bad_in, last_t, wr_en, rd_en;
  logic [CMP_W-1:0] idx_ext;
  logic [AW-1:0]    rd_addr;
  tori_row_t        wr_row, rd_row;
  logic             ctx_valid, hit, cand_active;
  tori_ctx_t        ctx;

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign idx_ext = CMP_W'(in_data.tri_index);
  assign bad_in  = idx_ext >= CMP_W'(count_r);
  assign last_t  = (CNT_W'(t_r) == count_r - 1'b1);
  assign wr_en   = accept && (in_data.mode == MODE_APPEND) &&
                   (count_r < CNT_W'(MAX_TRIANGLES));
  assign wr_row  = {in_data.v2_z, in_data.v2_y, in_data.v2_x,
                    in_data.v1_z, in_data.v1_y, in_data.v1_x,
                    in_data.v0_z, in_data.v0_y, in_data.v0_x};
  assign flips_nxt = (parity_r && (flips_r < FLIP_W'(FLIP_TOTAL_MAX))) ?
                     flips_r + 1'b1 : flips_r;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = t_r;
    if (accept && (in_data.mode == MODE_TEST) && !bad_in) begin
      rd_en   = 1'b1;
      rd_addr = idx_ext[AW-1:0];
    end else if (state_r == ST_SCAN) begin
      rd_en = 1'b1;
    end
  end

  tori_store #(.DEPTH(MAX_TRIANGLES), .AW(AW)) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(count_r[AW-1:0]),
    .wr_row (wr_row),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_row (rd_row)
  );

  tori_setup u_setup (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load_r),
    .row      (rd_row),
    .cfg      (cfg_r),
    .ctx_valid(ctx_valid),
    .ctx      (ctx)
  );

  tori_cand u_cand (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(rd_pend_r),
    .is_self (self_r),
    .row     (rd_row),
    .ctx     (ctx),
    .hit     (hit),
    .active  (cand_active)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      count_r       <= '0;
      flips_r       <= '0;
      out_valid_r   <= 1'b0;
      load_r        <= 1'b0;
      rd_pend_r     <= 1'b0;
      parity_r      <= 1'b0;
      cfg_r.x_low   <= '0;
      cfg_r.x_high  <= '0;
      cfg_r.y_low   <= '0;
      cfg_r.y_high  <= '0;
      cfg_r.z_low   <= '0;
      cfg_r.z_high  <= '0;
      cfg_r.margin  <= MARGIN_W'(1);
      cfg_r.three_d <= 1'b1;
    end else begin
      out_valid_r <= 1'b0;
      load_r      <= 1'b0;
      rd_pend_r   <= (state_r == ST_SCAN);
      self_r      <= (t_r == q_r);
      if (hit) begin
        parity_r <= ~parity_r;
      end
      if (cfg_we) begin
        case (cfg_idx)
          REG_X_LOW:   cfg_r.x_low   <= cfg_data;
          REG_X_HIGH:  cfg_r.x_high  <= cfg_data;
          REG_Y_LOW:   cfg_r.y_low   <= cfg_data;
          REG_Y_HIGH:  cfg_r.y_high  <= cfg_data;
          REG_Z_LOW:   cfg_r.z_low   <= cfg_data;
          REG_Z_HIGH:  cfg_r.z_high  <= cfg_data;
          REG_MARGIN:  cfg_r.margin  <= cfg_data[MARGIN_W-1:0];
          REG_THREE_D: cfg_r.three_d <= cfg_data[0];
          default: ;
        endcase
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            case (in_data.mode)
              MODE_CLEAR: begin
                count_r <= '0;
                flips_r <= '0;
              end
              MODE_APPEND: begin
                if (wr_en) count_r <= count_r + 1'b1;
              end
              MODE_TEST: begin
                idx_r <= in_data.tri_index;
                q_r   <= idx_ext[AW-1:0];
                if (bad_in) begin
                  out_valid_r <= 1'b1;
                  out_r       <= '{tested_index: in_data.tri_index, flip: 1'b0,
                                   bad_index: 1'b1, flip_total: flips_r};
                end else begin
                  load_r  <= 1'b1;
                  state_r <= ST_SETUP;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SETUP: begin
          if (ctx_valid) begin
            if (ctx.skip) begin
              out_valid_r <= 1'b1;
              out_r       <= '{tested_index: idx_r, flip: 1'b0,
                               bad_index: 1'b0, flip_total: flips_r};
              state_r     <= ST_IDLE;
            end else begin
              t_r      <= '0;
              parity_r <= 1'b0;
              state_r  <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          t_r <= t_r + 1'b1;
          if (last_t) state_r <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (!rd_pend_r && !cand_active) begin
            flips_r     <= flips_nxt;
            out_valid_r <= 1'b1;
            out_r       <= '{tested_index: idx_r, flip: parity_r,
                             bad_index: 1'b0, flip_total: flips_nxt};
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

/* design/tori_store.sv */
// ---------------------------------------------------------------------------
// tori_store
// Triangle store: one row of nine coordinates per triangle, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module tori_store import tori_pkg::*; #(
  parameter int DEPTH = MAX_TRIANGLES_DEF,
  parameter int AW    = $clog2(MAX_TRIANGLES_DEF)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  tori_row_t     wr_row,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output tori_row_t     rd_row
);

  tori_row_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_row <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* design/tori_setup.sv */
// ---------------------------------------------------------------------------
// tori_setup
// Query triangle setup: normal, dominant axis, ray bounds and skip decision.
// ---------------------------------------------------------------------------
`default_nettype none

module tori_setup import tori_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  tori_row_t row,
  input  tori_cfg_t cfg,
  output logic      ctx_valid,
  output tori_ctx_t ctx
);

  logic signed [COORD_BITS-1:0] c [3][3];
  logic signed [EDGE_W-1:0]     e1_r [3];
  logic signed [EDGE_W-1:0]     e2_r [3];
  logic signed [SUM_W-1:0]      suma_r [3];
  logic signed [SUM_W-1:0]      sumb_r [3];
  logic signed [SUM_W-1:0]      sumc_r [3];
  logic signed [SUM_W-1:0]      sumd_r [3];
  logic signed [NPROD_W-1:0]    p_r [6];
  logic signed [N_W-1:0]        n_r [3];
  logic [N_W-1:0]               an [3];
  logic [1:0]                   k_sel;
  logic [1:0]                   k_r;
  logic                         npos_r;
  logic                         nzero_r;
  logic signed [CFG_W-1:0]      lo;
  logic signed [CFG_W-1:0]      hi;
  logic signed [CFG_W:0]        dl;
  logic signed [SUM_W-1:0]      sumk;
  logic                         va_r, vb_r, vc_r, vd_r, ve_r;

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      for (int a = 0; a < 3; a++) begin
        c[v][a] = row[v*3+a];
      end
    end
    for (int a = 0; a < 3; a++) begin
      an[a] = n_r[a][N_W-1] ? (~n_r[a] + 1'b1) : n_r[a];
    end
    if (an[0] >= an[1]) begin
      k_sel = (an[0] < an[2]) ? AX_Z : AX_X;
    end else begin
      k_sel = (an[1] < an[2]) ? AX_Z : AX_Y;
    end
    case (k_r)
      AX_X: begin
        lo = cfg.x_low;
        hi = cfg.x_high;
      end
      AX_Y: begin
        lo = cfg.y_low;
        hi = cfg.y_high;
      end
      default: begin
        lo = cfg.z_low;
        hi = cfg.z_high;
      end
    endcase
    dl   = hi - lo;
    sumk = sumd_r[k_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else begin
      va_r <= load;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
    end
    if (load) begin
      for (int a = 0; a < 3; a++) begin
        e1_r[a]   <= c[1][a] - c[0][a];
        e2_r[a]   <= c[2][a] - c[0][a];
        suma_r[a] <= c[0][a] + c[1][a] + c[2][a];
      end
    end
    if (va_r) begin
      p_r[0] <= e1_r[1] * e2_r[2];
      p_r[1] <= e2_r[1] * e1_r[2];
      p_r[2] <= e2_r[0] * e1_r[2];
      p_r[3] <= e1_r[0] * e2_r[2];
      p_r[4] <= e1_r[0] * e2_r[1];
      p_r[5] <= e2_r[0] * e1_r[1];
      sumb_r <= suma_r;
    end
    if (vb_r) begin
      n_r[0] <= p_r[0] - p_r[1];
      n_r[1] <= p_r[2] - p_r[3];
      n_r[2] <= p_r[4] - p_r[5];
      sumc_r <= sumb_r;
    end
    if (vc_r) begin
      k_r     <= k_sel;
      npos_r  <= !n_r[k_sel][N_W-1] && (n_r[k_sel] != '0);
      nzero_r <= (n_r[k_sel] == '0);
      sumd_r  <= sumc_r;
    end
    if (vd_r) begin
      ctx.skip   <= ((k_r == AX_Y) && !cfg.three_d) || nzero_r || (dl == '0);
      ctx.k      <= k_r;
      ctx.ls_neg <= dl[CFG_W];
      ctx.lo3    <= npos_r ? sumk : 3 * lo;
      ctx.hi3    <= npos_r ? 3 * hi : sumk;
      ctx.sum0   <= sumd_r[0];
      ctx.sum1   <= sumd_r[1];
      ctx.sum2   <= sumd_r[2];
      ctx.margin <= cfg.margin;
    end
  end

  assign ctx_valid = ve_r;

endmodule

`default_nettype wire

/* design/tori_cand.sv */
// ---------------------------------------------------------------------------
// tori_cand
// Candidate pipeline: box test, signed weights, hit position against bounds.
// ---------------------------------------------------------------------------
`default_nettype none

module tori_cand import tori_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      is_self,
  input  tori_row_t row,
  input  tori_ctx_t ctx,
  output logic      hit,
  output logic      active
);

  logic signed [COORD_BITS-1:0] c [3][3];
  logic signed [SUM_W-1:0]      s [3];
  logic signed [COORD_BITS-1:0] mn [3];
  logic signed [COORD_BITS-1:0] mx [3];
  logic signed [COORD_BITS:0]   lowm [3];
  logic signed [COORD_BITS:0]   highm [3];
  logic signed [P3_W-1:0]       lowb [3];
  logic signed [P3_W-1:0]       highb [3];
  logic signed [P3_W-1:0]       p3 [3][3];
  logic signed [P3_W-1:0]       pi [3];
  logic signed [P3_W-1:0]       pj [3];
  logic signed [P3_W-1:0]       ma [3];
  logic signed [P3_W-1:0]       mb [3];
  logic [1:0]                   ai, aj;
  logic                         box_ok;

  logic                         v1_r, v2_r, v3_r, v4_r, v5_r;
  logic signed [P3_W-1:0]       pi1_r [3];
  logic signed [P3_W-1:0]       pj1_r [3];
  logic signed [P3_W-1:0]       ma1_r [3];
  logic signed [P3_W-1:0]       mb1_r [3];
  logic signed [PROD_W-1:0]     pr2_r [6];
  logic signed [P3_W-1:0]       ma2_r [3];
  logic signed [P3_W-1:0]       mb2_r [3];
  logic signed [UVW_W-1:0]      uvw3_r [3];
  logic signed [P3_W-1:0]       ma3_r [3];
  logic signed [P3_W-1:0]       mb3_r [3];
  logic signed [SPLIT:0]        ulo [3];
  logic signed [HI_W-1:0]       uhi [3];
  logic                         neg [3];
  logic                         zer [3];
  logic signed [D_W-1:0]        d;
  logic                         pass;
  logic signed [UVW_W-1:0]      pla4_r [3];
  logic signed [UVW_W-1:0]      pha4_r [3];
  logic signed [UVW_W-1:0]      plb4_r [3];
  logic signed [UVW_W-1:0]      phb4_r [3];
  logic                         go4_r, dneg4_r;
  logic signed [E_W-1:0]        ta5_r [3];
  logic signed [E_W-1:0]        tb5_r [3];
  logic                         go5_r, dneg5_r;
  logic signed [E_W-1:0]        ea6_r, eb6_r;
  logic                         go6_r, dneg6_r, v6_r;

  // stage 0: box test, centred coordinates, bound multipliers
  always_comb begin
    s[0] = ctx.sum0;
    s[1] = ctx.sum1;
    s[2] = ctx.sum2;
    box_ok = 1'b1;
    for (int v = 0; v < 3; v++) begin
      for (int a = 0; a < 3; a++) begin
        c[v][a]  = row[v*3+a];
        p3[v][a] = 3 * c[v][a] - s[a];
      end
    end
    for (int a = 0; a < 3; a++) begin
      mn[a] = c[0][a];
      mx[a] = c[0][a];
      for (int v = 1; v < 3; v++) begin
        if (c[v][a] < mn[a]) mn[a] = c[v][a];
        if (c[v][a] > mx[a]) mx[a] = c[v][a];
      end
      lowm[a]  = mn[a] - $signed({1'b0, ctx.margin});
      highm[a] = mx[a] + $signed({1'b0, ctx.margin});
      lowb[a]  = 3 * lowm[a];
      highb[a] = 3 * highm[a];
      if ((2'(a) != ctx.k) && ((s[a] < lowb[a]) || (s[a] > highb[a]))) box_ok = 1'b0;
    end
    case (ctx.k)
      AX_X: begin
        ai = AX_Y;
        aj = AX_Z;
      end
      AX_Y: begin
        ai = AX_Z;
        aj = AX_X;
      end
      default: begin
        ai = AX_X;
        aj = AX_Y;
      end
    endcase
    for (int v = 0; v < 3; v++) begin
      pi[v] = p3[v][ai];
      pj[v] = p3[v][aj];
      ma[v] = 3 * c[v][ctx.k] - ctx.lo3;
      mb[v] = 3 * c[v][ctx.k] - ctx.hi3;
    end
  end

  // stage 3: sign test, weight sum, split for the wide products
  always_comb begin
    for (int w = 0; w < 3; w++) begin
      neg[w] = uvw3_r[w][UVW_W-1];
      zer[w] = (uvw3_r[w] == '0);
      ulo[w] = {1'b0, uvw3_r[w][SPLIT-1:0]};
      uhi[w] = uvw3_r[w][UVW_W-1:SPLIT];
    end
    if (ctx.ls_neg) begin
      pass = ((neg[0] || zer[0]) && (neg[1] || zer[1]) && (neg[2] || zer[2])) ||
             (!neg[0] && !zer[0] && !neg[1] && !zer[1] && !neg[2] && !zer[2]);
    end else begin
      pass = (!neg[0] && !neg[1] && !neg[2]) || (neg[0] && neg[1] && neg[2]);
    end
    d = uvw3_r[0] + uvw3_r[1] + uvw3_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v1_r <= in_valid && !is_self && box_ok;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
    pi1_r <= pi;
    pj1_r <= pj;
    ma1_r <= ma;
    mb1_r <= mb;

    pr2_r[0] <= pi1_r[2] * pj1_r[1];
    pr2_r[1] <= pj1_r[2] * pi1_r[1];
    pr2_r[2] <= pi1_r[0] * pj1_r[2];
    pr2_r[3] <= pj1_r[0] * pi1_r[2];
    pr2_r[4] <= pi1_r[1] * pj1_r[0];
    pr2_r[5] <= pj1_r[1] * pi1_r[0];
    ma2_r    <= ma1_r;
    mb2_r    <= mb1_r;

    uvw3_r[0] <= pr2_r[0] - pr2_r[1];
    uvw3_r[1] <= pr2_r[2] - pr2_r[3];
    uvw3_r[2] <= pr2_r[4] - pr2_r[5];
    ma3_r     <= ma2_r;
    mb3_r     <= mb2_r;

    for (int w = 0; w < 3; w++) begin
      pla4_r[w] <= ulo[w] * ma3_r[w];
      pha4_r[w] <= uhi[w] * ma3_r[w];
      plb4_r[w] <= ulo[w] * mb3_r[w];
      phb4_r[w] <= uhi[w] * mb3_r[w];
    end
    go4_r   <= pass && (d != '0);
    dneg4_r <= d[D_W-1];

    for (int w = 0; w < 3; w++) begin
      ta5_r[w] <= (E_W'(pha4_r[w]) <<< SPLIT) + E_W'(pla4_r[w]);
      tb5_r[w] <= (E_W'(phb4_r[w]) <<< SPLIT) + E_W'(plb4_r[w]);
    end
    go5_r   <= go4_r;
    dneg5_r <= dneg4_r;

    ea6_r   <= ta5_r[0] + ta5_r[1] + ta5_r[2];
    eb6_r   <= tb5_r[0] + tb5_r[1] + tb5_r[2];
    go6_r   <= go5_r;
    dneg6_r <= dneg5_r;
  end

  assign hit = v6_r && go6_r &&
               (dneg6_r ? ((ea6_r <= 0) && (eb6_r >= 0)) : ((ea6_r >= 0) && (eb6_r <= 0)));
  assign active = v1_r || v2_r || v3_r || v4_r || v5_r || v6_r;

endmodule

`default_nettype wire

/* design/tori_checker.sv */
// ---------------------------------------------------------------------------
// tori_checker
// Port-level checks on result beats, flip total and reset behaviour.
// ---------------------------------------------------------------------------
`default_nettype none

module tori_checker import tori_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input tori_in_t  in_data,
  input logic      out_valid,
  input tori_out_t out_data
);

  a_bad_no_flip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_index |-> !out_data.flip)
    else $error("bad index beat reports a flip");

  a_flip_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.flip |-> out_data.flip_total != '0)
    else $error("flip beat with zero flip total");

  a_total_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.flip_total <= FLIP_W'(FLIP_TOTAL_MAX))
    else $error("flip total beyond saturation");

  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_data.mode != MODE_TEST) |=> !out_valid)
    else $error("result beat after clear or append");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("busy or result beat after reset");

endmodule

bind triangle_orientation_ray_parity tori_checker u_tori_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_data (out_data)
);

`default_nettype wire
